### hw/rtl/cfq_pkg.sv
// shared types, codes and constants for the circular fifo queue
`default_nettype none
package cfq_pkg;

   // sizes
   localparam int DEPTH_DEF = 128;
   localparam int WORD_W    = 32;
   localparam int REQ_W     = 3;
   localparam int STATUS_W  = 2;

   // request codes
   localparam logic [REQ_W-1:0] REQ_INSERT      = 3'd0;
   localparam logic [REQ_W-1:0] REQ_PEEK        = 3'd1;
   localparam logic [REQ_W-1:0] REQ_REMOVE      = 3'd2;
   localparam logic [REQ_W-1:0] REQ_PEEK_REMOVE = 3'd3;
   localparam logic [REQ_W-1:0] REQ_CLEAR       = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

   // control broadcast to every storage cell
   typedef struct packed {
      logic shift;   // drop the head word, every cell takes its upper neighbor
      logic insert;  // the cell at the fill position loads the new word
   } cell_ctrl_type;

endpackage
`default_nettype wire

### hw/rtl/cfq_cell.sv
// one storage cell of the queue chain
`default_nettype none
module cfq_cell #(
   parameter int CNT_W = 8,
   parameter int IDX   = 0
) (
   input  wire                             clock,
   input  wire  cfq_pkg::cell_ctrl_type    ctrl,
   input  wire  [CNT_W-1:0]                fill,
   input  wire  signed [cfq_pkg::WORD_W-1:0] ins_word,
   input  wire  signed [cfq_pkg::WORD_W-1:0] next_word,
   output logic signed [cfq_pkg::WORD_W-1:0] word
);

   logic signed [cfq_pkg::WORD_W-1:0] word_ff;
   logic signed [cfq_pkg::WORD_W-1:0] word_in;

   // shift toward the head, or load the incoming word at the fill position
   always_comb begin
      word_in = word_ff;
      if (ctrl.shift) begin
         word_in = next_word;
      end else if (ctrl.insert && (fill == CNT_W'(IDX))) begin
         word_in = ins_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule
`default_nettype wire

### hw/rtl/circular_fifo_queue.sv
// top level of the circular fifo queue: request decode, fill count and cell chain
`default_nettype none
// FIFO of DEPTH signed 32-bit words. Each request (insert, peek, remove,
// peek and remove, clear) gives exactly one response word carrying the head
// word read, a status code, the occupancy after the request and an empty
// flag. A request is taken in every cycle while the response register is
// free or being drained in the same cycle, so the block sustains one request
// per clock; the response appears in the cycle after the request is taken.
// Storage is a row of cells: cell 0 always holds the oldest word, an insert
// loads the cell at the current fill position, and a remove shifts the whole
// row one place toward the head. Errors (insert when full, read or remove
// when empty) leave the contents and the count unchanged.
module circular_fifo_queue #(
   parameter int DEPTH = cfq_pkg::DEPTH_DEF,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire  [cfq_pkg::REQ_W-1:0]         req_type,
   input  wire  signed [cfq_pkg::WORD_W-1:0] req_data_in,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic signed [cfq_pkg::WORD_W-1:0] rsp_data_out,
   output logic [cfq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [CNT_W-1:0]                  rsp_occupancy,
   output logic                              rsp_is_empty
);

   logic [CNT_W-1:0]                  count_ff;
   logic [CNT_W-1:0]                  count_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic signed [cfq_pkg::WORD_W-1:0] rsp_data_ff;
   logic signed [cfq_pkg::WORD_W-1:0] rsp_data_in;
   logic [cfq_pkg::STATUS_W-1:0]      rsp_status_ff;
   logic [cfq_pkg::STATUS_W-1:0]      rsp_status_in;
   logic [CNT_W-1:0]                  rsp_occ_ff;
   logic                              rsp_empty_ff;

   logic                              accept;
   logic                              full;
   logic                              empty;
   logic                              do_shift;
   logic                              do_insert;
   cfq_pkg::cell_ctrl_type            ctrl;
   logic signed [cfq_pkg::WORD_W-1:0] cell_word [DEPTH];

   // take a word whenever the response register is free or draining
   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);

   // request decode
   always_comb begin
      count_in      = count_ff;
      rsp_data_in   = '0;
      rsp_status_in = cfq_pkg::ST_OK;
      do_shift      = 1'b0;
      do_insert     = 1'b0;
      case (req_type)
         cfq_pkg::REQ_INSERT: begin
            if (full) begin
               rsp_status_in = cfq_pkg::ST_OVERFLOW;
            end else begin
               do_insert = 1'b1;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         cfq_pkg::REQ_PEEK, cfq_pkg::REQ_REMOVE, cfq_pkg::REQ_PEEK_REMOVE: begin
            if (empty) begin
               rsp_status_in = cfq_pkg::ST_EMPTY;
            end else begin
               if (req_type != cfq_pkg::REQ_REMOVE) begin
                  rsp_data_in = cell_word[0];
               end
               if (req_type != cfq_pkg::REQ_PEEK) begin
                  do_shift = 1'b1;
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         cfq_pkg::REQ_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign ctrl.shift  = accept && do_shift;
   assign ctrl.insert = accept && do_insert;

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
         rsp_occ_ff    <= count_in;
         rsp_empty_ff  <= (count_in == '0);
      end
   end

   // storage chain, cell 0 holds the head word
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i < DEPTH - 1) begin : g_mid
         cfq_cell #(.CNT_W(CNT_W), .IDX(i)) u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .fill      (count_ff),
            .ins_word  (req_data_in),
            .next_word (cell_word[i+1]),
            .word      (cell_word[i])
         );
      end else begin : g_last
         cfq_cell #(.CNT_W(CNT_W), .IDX(i)) u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .fill      (count_ff),
            .ins_word  (req_data_in),
            .next_word (req_data_in),
            .word      (cell_word[i])
         );
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_out  = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;
   assign rsp_is_empty  = rsp_empty_ff;

endmodule
`default_nettype wire

### hw/rtl/cfq_checker.sv
// port-level checks for the circular fifo queue and their bind
`default_nettype none
module cfq_checker #(
   parameter int DEPTH = cfq_pkg::DEPTH_DEF,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_valid,
   input wire                               req_ready,
   input wire                               rsp_valid,
   input wire                               rsp_ready,
   input wire signed [cfq_pkg::WORD_W-1:0]  rsp_data_out,
   input wire [cfq_pkg::STATUS_W-1:0]       rsp_status,
   input wire [CNT_W-1:0]                   rsp_occupancy,
   input wire                               rsp_is_empty
);

   // empty flag agrees with the occupancy
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_occupancy == '0)))
      else $error("empty flag disagrees with occupancy");

   // an overflow is only reported on a full queue
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == cfq_pkg::ST_OVERFLOW)
         |-> (rsp_occupancy == CNT_W'(DEPTH) && rsp_data_out == '0))
      else $error("overflow reported on a queue that is not full");

   // an empty error leaves the queue empty and reads nothing
   a_empty_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == cfq_pkg::ST_EMPTY)
         |-> (rsp_is_empty && rsp_data_out == '0))
      else $error("empty error on a queue that holds words");

   // every accepted request gives a response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted request produced no response");

   // a stalled response holds its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data_out)
         && $stable(rsp_status) && $stable(rsp_occupancy)))
      else $error("stalled response changed");

endmodule

bind circular_fifo_queue cfq_checker #(.DEPTH(DEPTH)) u_cfq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_data_out  (rsp_data_out),
   .rsp_status    (rsp_status),
   .rsp_occupancy (rsp_occupancy),
   .rsp_is_empty  (rsp_is_empty)
);
`default_nettype wire

### dv/tb_circular_fifo_queue.sv
// self-checking testbench for the circular fifo queue: driver, monitor, predictor
`timescale 1ns / 1ps

module tb_circular_fifo_queue;

   localparam int REQ_W    = cfq_pkg::REQ_W;
   localparam int WORD_W   = cfq_pkg::WORD_W;
   localparam int STATUS_W = cfq_pkg::STATUS_W;
   localparam int PTR_W    = $clog2(cfq_pkg::DEPTH_DEF);
   localparam int CNT_W    = $clog2(cfq_pkg::DEPTH_DEF + 1);

   // request codes the block ignores
   localparam logic [REQ_W-1:0] REQ_SPARE_LO  = 3'd5;
   localparam logic [REQ_W-1:0] REQ_SPARE_MID = 3'd6;
   localparam logic [REQ_W-1:0] REQ_SPARE_HI  = 3'd7;

   typedef struct {
      logic [REQ_W-1:0]         op;
      logic signed [WORD_W-1:0] word;
   } fifo_request_type;

   typedef struct {
      logic signed [WORD_W-1:0] data_out;
      logic [STATUS_W-1:0]      status;
      logic [CNT_W-1:0]         occupancy;
      logic                     is_empty;
   } fifo_response_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [REQ_W-1:0]         req_type = '0;
   logic signed [WORD_W-1:0] req_data_in = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [WORD_W-1:0] rsp_data_out;
   logic [STATUS_W-1:0]      rsp_status;
   logic [CNT_W-1:0]         rsp_occupancy;
   logic                     rsp_is_empty;

   // words waiting to be sent and responses still owed by the block
   fifo_request_type  pending_requests[$];
   fifo_response_type owed_responses[$];

   // shadow copy of the ring
   logic signed [WORD_W-1:0] shadow_slots[cfq_pkg::DEPTH_DEF];
   logic [PTR_W-1:0]         shadow_head;
   logic [PTR_W-1:0]         shadow_tail;
   logic [CNT_W-1:0]         shadow_count;

   bit idle_ok = 1'b1;
   int send_gap;
   int recv_hold;
   int queued_count;
   int accepted_count;
   int checked_count;
   int overflow_seen;
   int underflow_seen;
   int full_hits;
   int error_count;

   circular_fifo_queue #(
      .DEPTH(cfq_pkg::DEPTH_DEF)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_data_in  (req_data_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data_out (rsp_data_out),
      .rsp_status   (rsp_status),
      .rsp_occupancy(rsp_occupancy),
      .rsp_is_empty (rsp_is_empty)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // apply one request to the shadow ring and return the response it should give
   function automatic fifo_response_type apply_fifo_request(
      input logic [REQ_W-1:0] op, input logic signed [WORD_W-1:0] word);
      fifo_response_type r;
      r.data_out = '0;
      r.status   = cfq_pkg::ST_OK;
      case (op)
         cfq_pkg::REQ_INSERT: begin
            if (shadow_count == CNT_W'(cfq_pkg::DEPTH_DEF)) begin
               r.status = cfq_pkg::ST_OVERFLOW;
            end else begin
               shadow_tail = (shadow_tail == PTR_W'(cfq_pkg::DEPTH_DEF - 1)) ? '0
                             : shadow_tail + 1'b1;
               shadow_slots[shadow_tail] = word;
               shadow_count = shadow_count + 1'b1;
            end
         end
         cfq_pkg::REQ_PEEK, cfq_pkg::REQ_REMOVE, cfq_pkg::REQ_PEEK_REMOVE: begin
            if (shadow_count == '0) begin
               r.status = cfq_pkg::ST_EMPTY;
            end else begin
               if (op != cfq_pkg::REQ_REMOVE) r.data_out = shadow_slots[shadow_head];
               if (op != cfq_pkg::REQ_PEEK) begin
                  shadow_head = (shadow_head == PTR_W'(cfq_pkg::DEPTH_DEF - 1)) ? '0
                                : shadow_head + 1'b1;
                  shadow_count = shadow_count - 1'b1;
               end
            end
         end
         cfq_pkg::REQ_CLEAR: begin
            shadow_head  = '0;
            shadow_tail  = PTR_W'(cfq_pkg::DEPTH_DEF - 1);
            shadow_count = '0;
         end
         default: ;
      endcase
      r.occupancy = shadow_count;
      r.is_empty  = (shadow_count == '0);
      return r;
   endfunction

   task automatic check_field(input string field, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   task automatic push_request(input logic [REQ_W-1:0] op, input logic [WORD_W-1:0] word);
      fifo_request_type w;
      w.op   = op;
      w.word = word;
      pending_requests.push_back(w);
      if (op <= cfq_pkg::REQ_CLEAR) queued_count++;
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || owed_responses.size() != 0)
         @(posedge clock);
   endtask

   // mostly random words, with the extremes mixed in
   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(0, 15))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // request driver, also feeds the predictor on each accepted word
   always @(posedge clock) begin
      fifo_request_type nxt;
      if (reset) begin
         req_valid    <= 1'b0;
         send_gap     = 0;
         shadow_head  = '0;
         shadow_tail  = PTR_W'(cfq_pkg::DEPTH_DEF - 1);
         shadow_count = '0;
      end else begin
         if (req_valid && req_ready) begin
            // count the times the queue is filled completely
            if (req_type == cfq_pkg::REQ_INSERT
                && shadow_count == CNT_W'(cfq_pkg::DEPTH_DEF - 1))
               full_hits++;
            owed_responses.push_back(apply_fifo_request(req_type, req_data_in));
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (idle_ok && pending_requests.size() != 0
                         && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 5);
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               nxt = pending_requests.pop_front();
               req_type    <= nxt.op;
               req_data_in <= nxt.word;
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random back-pressure
   always @(posedge clock) begin
      fifo_response_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_responses.size() == 0) begin
               error_count++;
               $display("%0t ns: unexpected response, expected none, actual data %0h status %0d",
                        $time, rsp_data_out, rsp_status);
            end else begin
               want = owed_responses.pop_front();
               checked_count++;
               if (want.status == cfq_pkg::ST_OVERFLOW) overflow_seen++;
               if (want.status == cfq_pkg::ST_EMPTY) underflow_seen++;
               check_field("data_out", want.data_out, rsp_data_out);
               check_field("status", WORD_W'(want.status), WORD_W'(rsp_status));
               check_field("occupancy", WORD_W'(want.occupancy), WORD_W'(rsp_occupancy));
               check_field("is_empty", WORD_W'(want.is_empty), WORD_W'(rsp_is_empty));
            end
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_ready <= 1'b0;
         end else if (idle_ok && $urandom_range(0, 7) == 0) begin
            recv_hold = $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // stimulus
   initial begin
      int phase;
      int sel;
      int n;
      int pick;
      bit paused;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reads on an empty queue, extremes, every request code
      push_request(cfq_pkg::REQ_PEEK, 32'h1234_5678);
      push_request(cfq_pkg::REQ_REMOVE, '0);
      push_request(cfq_pkg::REQ_PEEK_REMOVE, '0);
      push_request(cfq_pkg::REQ_CLEAR, '0);
      push_request(REQ_SPARE_LO, 32'hFFFF_FFFF);
      push_request(cfq_pkg::REQ_INSERT, 32'h7FFF_FFFF);
      push_request(cfq_pkg::REQ_INSERT, 32'h8000_0000);
      push_request(cfq_pkg::REQ_INSERT, 32'h0000_0000);
      push_request(cfq_pkg::REQ_INSERT, 32'hFFFF_FFFF);
      push_request(REQ_SPARE_MID, 32'h5555_5555);
      push_request(cfq_pkg::REQ_PEEK, '0);
      push_request(cfq_pkg::REQ_PEEK_REMOVE, '0);
      push_request(cfq_pkg::REQ_REMOVE, '0);
      push_request(REQ_SPARE_HI, 32'hAAAA_AAAA);
      push_request(cfq_pkg::REQ_PEEK_REMOVE, '0);
      push_request(cfq_pkg::REQ_PEEK, '0);
      push_request(cfq_pkg::REQ_CLEAR, '0);
      push_request(cfq_pkg::REQ_PEEK, '0);
      push_request(cfq_pkg::REQ_INSERT, 32'h5A5A_A5A5);
      push_request(cfq_pkg::REQ_PEEK_REMOVE, '0);
      push_request(cfq_pkg::REQ_REMOVE, '0);
      wait_drained();

      // random phases: a run of inserts to fill the queue, a run of peeks and removes to drain it, or a mixed walk
      phase  = 0;
      paused = 1'b0;
      while (queued_count < 1420) begin
         while (pending_requests.size() > 4) @(posedge clock);
         if (!paused && queued_count >= 700) begin
            wait_drained();
            paused = 1'b1;
         end
         idle_ok = (queued_count < 1250) && ($urandom_range(0, 3) != 0);
         sel = (phase < 2) ? phase : $urandom_range(0, 9);
         n   = (sel <= 1) ? $urandom_range(128, 140) : $urandom_range(10, 50);
         repeat (n) begin
            if (sel == 0) begin
               push_request(cfq_pkg::REQ_INSERT, random_word());
            end else if (sel == 1) begin
               push_request(REQ_W'($urandom_range(1, 3)), random_word());
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 46)      push_request(cfq_pkg::REQ_INSERT, random_word());
               else if (pick < 61) push_request(cfq_pkg::REQ_PEEK, random_word());
               else if (pick < 76) push_request(cfq_pkg::REQ_REMOVE, random_word());
               else if (pick < 94) push_request(cfq_pkg::REQ_PEEK_REMOVE, random_word());
               else if (pick < 97) push_request(cfq_pkg::REQ_CLEAR, random_word());
               else push_request(REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)),
                                 random_word());
            end
         end
         phase++;
      end

      wait_drained();
      repeat (10) @(posedge clock);
      $display("Run summary: %0d requests sent, %0d responses checked", accepted_count,
               checked_count);
      $display("Run summary: %0d overflow and %0d empty-read errors, queue filled %0d times",
               overflow_seen, underflow_seen, full_hits);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("Timeout waiting for the block");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
